>>> sv/snws_pkg.sv
// shared types and constants for the serial novram word store
package snws_pkg;

    // number of ram words and of their nonvolatile shadow words
    localparam int WORD_COUNT = 16;

    // fixed field widths
    localparam int REQ_W  = 3;
    localparam int ADDR_W = 4;
    localparam int WORD_W = 16;

    // derived widths
    localparam int IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W = IDX_W + 1;

    // command codes
    localparam logic [REQ_W-1:0] REQ_WRDS  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_STO   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WREN  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RCL   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic             rd_en;      // registered read of one word
        logic             rd_shadow;  // read the shadow instead of ram
        logic [IDX_W-1:0] rd_idx;
        logic             ram_wr_host; // host write of i_write_word
        logic             ram_wr_copy; // recall write from read register
        logic             sh_wr_copy;  // store write from read register
        logic [IDX_W-1:0] wr_idx;
        logic             out_load;   // load the output register
        logic             out_read;   // output carries the read word
        logic             out_perf;
    } t_dp_cmd;

endpackage

>>> sv/snws_dp.sv
// datapath: ram and shadow word stores, read register and output register
module snws_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  snws_pkg::t_dp_cmd                   i_cmd,
    input  logic [snws_pkg::WORD_W-1:0]         i_write_word,
    output logic [snws_pkg::WORD_W-1:0]         o_read_word,
    output logic                                o_performed
);

    logic [snws_pkg::WORD_W-1:0]     r_ram    [snws_pkg::WORD_COUNT];
    logic [snws_pkg::WORD_W-1:0]     r_shadow [snws_pkg::WORD_COUNT];
    logic [snws_pkg::WORD_COUNT-1:0] r_ram_vld;
    logic [snws_pkg::WORD_COUNT-1:0] r_sh_vld;
    logic [snws_pkg::WORD_W-1:0]     r_rd_data;
    logic [snws_pkg::WORD_W-1:0]     r_read_word;
    logic                            r_performed;

    // per-entry valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_vld <= '0;
            r_sh_vld  <= '0;
        end else begin
            if (i_cmd.ram_wr_host || i_cmd.ram_wr_copy) begin
                r_ram_vld[i_cmd.wr_idx] <= 1'b1;
            end
            if (i_cmd.sh_wr_copy) begin
                r_sh_vld[i_cmd.wr_idx] <= 1'b1;
            end
        end
    end

    // ram store
    always_ff @(posedge i_clk) begin
        if (i_cmd.ram_wr_host) begin
            r_ram[i_cmd.wr_idx] <= i_write_word;
        end else if (i_cmd.ram_wr_copy) begin
            r_ram[i_cmd.wr_idx] <= r_rd_data;
        end
    end

    // shadow store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sh_wr_copy) begin
            r_shadow[i_cmd.wr_idx] <= r_rd_data;
        end
    end

    // registered read, masked by the valid bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            if (i_cmd.rd_shadow) begin
                r_rd_data <= r_sh_vld[i_cmd.rd_idx] ? r_shadow[i_cmd.rd_idx] : '0;
            end else begin
                r_rd_data <= r_ram_vld[i_cmd.rd_idx] ? r_ram[i_cmd.rd_idx] : '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_read_word <= i_cmd.out_read ? r_rd_data : '0;
            r_performed <= i_cmd.out_perf;
        end
    end

    assign o_read_word = r_read_word;
    assign o_performed = r_performed;

endmodule

>>> sv/snws_ctrl.sv
// controller: command decode, write-enable latch, copy sequencer, handshakes
module snws_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [snws_pkg::REQ_W-1:0]        i_req_type,
    input  logic [snws_pkg::ADDR_W-1:0]       i_word_address,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output snws_pkg::t_dp_cmd                 o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_FIN
    } t_state;

    localparam logic [snws_pkg::CNT_W-1:0] CNT_END = snws_pkg::CNT_W'(snws_pkg::WORD_COUNT);
    localparam logic [snws_pkg::ADDR_W:0]  ADDR_LIM = (snws_pkg::ADDR_W + 1)'(snws_pkg::WORD_COUNT);

    t_state                       r_state, n_state;
    logic                         r_wen, n_wen;
    logic                         r_rcl, n_rcl;
    logic [snws_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_perf, n_perf;
    logic                         r_is_read, n_is_read;
    logic                         r_out_vld, n_out_vld;
    logic                         accept;
    logic                         addr_ok;
    logic                         out_free;
    logic [snws_pkg::IDX_W-1:0]   addr_idx;
    snws_pkg::t_dp_cmd            cmd;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign addr_ok     = ({1'b0, i_word_address} < ADDR_LIM);
    assign addr_idx    = i_word_address[snws_pkg::IDX_W-1:0];
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

    always_comb begin
        n_state   = r_state;
        n_wen     = r_wen;
        n_rcl     = r_rcl;
        n_cnt     = r_cnt;
        n_perf    = r_perf;
        n_is_read = r_is_read;
        n_out_vld = r_out_vld && i_out_stall;
        cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state   = S_FIN;
                    n_perf    = 1'b0;
                    n_is_read = 1'b0;
                    n_cnt     = '0;
                    unique case (i_req_type)
                        snws_pkg::REQ_WRDS: begin
                            n_wen  = 1'b0;
                            n_perf = 1'b1;
                        end
                        snws_pkg::REQ_WREN: begin
                            n_wen  = 1'b1;
                            n_perf = 1'b1;
                        end
                        snws_pkg::REQ_STO: begin
                            if (r_wen) begin
                                n_state = S_COPY;
                                n_rcl   = 1'b0;
                                n_perf  = 1'b1;
                            end
                        end
                        snws_pkg::REQ_RCL: begin
                            n_state = S_COPY;
                            n_rcl   = 1'b1;
                            n_perf  = 1'b1;
                        end
                        snws_pkg::REQ_WRITE: begin
                            if (r_wen && addr_ok) begin
                                cmd.ram_wr_host = 1'b1;
                                cmd.wr_idx      = addr_idx;
                                n_perf          = 1'b1;
                            end
                        end
                        snws_pkg::REQ_READ: begin
                            if (addr_ok) begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_idx = addr_idx;
                                n_is_read  = 1'b1;
                                n_perf     = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COPY: begin
                // read word cnt, write word cnt-1 from the read register
                cmd.rd_en       = (r_cnt < CNT_END);
                cmd.rd_shadow   = r_rcl;
                cmd.rd_idx      = r_cnt[snws_pkg::IDX_W-1:0];
                cmd.wr_idx      = snws_pkg::IDX_W'(r_cnt - 1'b1);
                cmd.ram_wr_copy = (r_cnt != '0) && r_rcl;
                cmd.sh_wr_copy  = (r_cnt != '0) && !r_rcl;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_END) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_read = r_is_read;
                    cmd.out_perf = r_perf;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wen     <= 1'b0;
            r_rcl     <= 1'b0;
            r_cnt     <= '0;
            r_perf    <= 1'b0;
            r_is_read <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wen     <= n_wen;
            r_rcl     <= n_rcl;
            r_cnt     <= n_cnt;
            r_perf    <= n_perf;
            r_is_read <= n_is_read;
            r_out_vld <= n_out_vld;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_vld || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish state");

    a_store_needs_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY && !r_rcl) |-> r_wen)
        else $error("store running with write enable clear");
`endif

endmodule

>>> sv/serial_novram_word_store_core.sv
// top level of the serial novram word store: 16 ram words with store and recall
//
// channel | direction | handshake                | payload
// --------+-----------+--------------------------+-------------------------------------
// in      | input     | i_in_valid / o_in_stall  | i_req_type, i_word_address, i_write_word
// out     | output    | o_out_valid / i_out_stall| o_read_word, o_performed
//
// one transaction in gives exactly one transaction out, in order
// latch, write, read and blocked commands go from accept to the finish state
// store and recall pass through the copy state before the finish state: the copy
//   sequencer moves one word a cycle through the single registered read port
// reset (synchronous, active low) clears the write-enable latch and the valid
//   bits of both stores, so every word reads as zero until written
// o_in_stall is high while a command is in work; a stalled result is held in
//   the output register and the next command is still accepted behind it
module serial_novram_word_store_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [snws_pkg::REQ_W-1:0]        i_req_type,
    input  logic [snws_pkg::ADDR_W-1:0]       i_word_address,
    input  logic [snws_pkg::WORD_W-1:0]       i_write_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [snws_pkg::WORD_W-1:0]       o_read_word,
    output logic                              o_performed
);

    // command bundle from the controller into the datapath
    snws_pkg::t_dp_cmd dp_cmd;

    // controller: decode, write-enable latch, copy counter, handshakes
    snws_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_word_address (i_word_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cmd          (dp_cmd)
    );

    // datapath: word stores, read register, result register
    snws_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_write_word (i_write_word),
        .o_read_word  (o_read_word),
        .o_performed  (o_performed)
    );

endmodule
